// ===== hdl/msvpt_pkg.sv =====
// ----------------------------------------------------------------------------
// msvpt_pkg: shared types and constants of the panorama pan/tilt mapper
// Word types, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package msvpt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 20;
  localparam int ZW             = 25;   // angle accumulator, 1/65536 degree
  localparam int CW             = 34;   // CORDIC x/y datapath
  localparam int BW             = 26;   // base tilt in 1/65536 degree
  localparam int OW             = 9;    // pan offset in degrees

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_BASE  = 3'd1;
  localparam logic [2:0] REG_VFOV  = 3'd2;
  localparam logic [2:0] REG_TAN   = 3'd3;
  localparam logic [2:0] REG_FRONT = 3'd4;

  typedef struct packed {
    logic [15:0] view_x;
    logic [15:0] view_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pan_angle;
    logic signed [15:0] tilt_angle;
  } out_word_t;

  typedef struct packed {
    logic               camera_mode;
    logic signed [14:0] base_tilt;
    logic [14:0]        vertical_fov;
    logic [18:0]        tan_half_vfov;
    logic [15:0]        front_face_fraction;
  } cfg_t;

  // data that rides along with an item past the CORDIC lanes
  typedef struct packed {
    logic signed [OW-1:0] pan_off;
    logic signed [BW-1:0] base;
  } side_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(2949120);
      1:  v = ZW'(1740967);
      2:  v = ZW'(919879);
      3:  v = ZW'(466945);
      4:  v = ZW'(234379);
      5:  v = ZW'(117304);
      6:  v = ZW'(58666);
      7:  v = ZW'(29335);
      8:  v = ZW'(14668);
      9:  v = ZW'(7334);
      10: v = ZW'(3667);
      11: v = ZW'(1833);
      12: v = ZW'(917);
      13: v = ZW'(458);
      14: v = ZW'(229);
      15: v = ZW'(115);
      16: v = ZW'(57);
      17: v = ZW'(29);
      18: v = ZW'(14);
      19: v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/msvpt_regs.sv =====
// ----------------------------------------------------------------------------
// msvpt_regs: configuration register file
// APB-style write/read of the five mapper registers.
// ----------------------------------------------------------------------------
module msvpt_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output msvpt_pkg::cfg_t     cfg
);
  import msvpt_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.camera_mode         <= 1'b0;
      cfg_r.base_tilt           <= '0;
      cfg_r.vertical_fov        <= 15'd11520;
      cfg_r.tan_half_vfov       <= 19'd65536;
      cfg_r.front_face_fraction <= 16'd32768;
    end else if (wr) begin
      case (idx)
        REG_MODE:  cfg_r.camera_mode         <= pwdata[0];
        REG_BASE:  cfg_r.base_tilt           <= signed'(pwdata[14:0]);
        REG_VFOV:  cfg_r.vertical_fov        <= pwdata[14:0];
        REG_TAN:   cfg_r.tan_half_vfov       <= pwdata[18:0];
        REG_FRONT: cfg_r.front_face_fraction <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_MODE:  prdata = {31'd0, cfg_r.camera_mode};
      REG_BASE:  prdata = {17'd0, cfg_r.base_tilt};
      REG_VFOV:  prdata = {17'd0, cfg_r.vertical_fov};
      REG_TAN:   prdata = {13'd0, cfg_r.tan_half_vfov};
      REG_FRONT: prdata = {16'd0, cfg_r.front_face_fraction};
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== hdl/msvpt_front.sv =====
// ----------------------------------------------------------------------------
// msvpt_front: operand stages
// Splits x into sensor segments, builds the tilt ratio and multiplies by tan.
// ----------------------------------------------------------------------------
module msvpt_front #(
  parameter int CB = msvpt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  msvpt_pkg::in_word_t          in_word,
  input  msvpt_pkg::cfg_t              cfg,
  output logic signed [CB+32:0]        pan_x,
  output logic signed [CB+32:0]        pan_y,
  output logic signed [CB+32:0]        tilt_x,
  output logic signed [CB+32:0]        tilt_y,
  output msvpt_pkg::side_t             side
);
  import msvpt_pkg::*;

  localparam int AW = CB + 13;
  localparam int NW = CB + 33;

  logic [CB-1:0]        xc, yc, ffc;
  logic [CB+15:0]       ff_sh;
  logic signed [AW-1:0] xw, yw, ffw, one_w, rw;
  logic signed [AW-1:0] ny_nxt, a_nxt, den_nxt, fbase;
  logic signed [OW-1:0] off_nxt;
  logic signed [BW-1:0] base_nxt, bt512;
  logic [1:0]           qidx;

  logic signed [AW-1:0] ny_r, a_r, den_r;
  side_t                side1_r, side2_r;
  logic signed [NW-1:0] pan_y_r, num_r, den2_r;

  // operand widening
  always_comb begin
    xc    = CB'({24'd0, in_word.view_x});
    yc    = CB'({24'd0, in_word.view_y});
    ff_sh = {cfg.front_face_fraction, CB'(0)};
    ffc   = ff_sh[CB+15:16];
    xw    = signed'(AW'(xc));
    yw    = signed'(AW'(yc));
    ffw   = signed'(AW'(ffc));
    one_w = AW'(1) <<< CB;
    qidx  = xc[CB-1 -: 2];
    rw    = signed'(AW'(xc[CB-3:0]));
    bt512 = BW'(cfg.base_tilt) <<< 9;
    fbase = AW'(25 * ffw + 4 * one_w);
  end

  // segment select and tilt ratio
  always_comb begin
    if (!cfg.camera_mode) begin
      ny_nxt = one_w - (rw <<< 3);
      case (qidx)
        2'd0:    off_nxt = OW'(135);
        2'd1:    off_nxt = OW'(45);
        2'd2:    off_nxt = -OW'(45);
        default: off_nxt = -OW'(135);
      endcase
      if ((yw <<< 1) <= one_w) begin
        a_nxt    = one_w - (yw <<< 1);
        den_nxt  = one_w;
        base_nxt = bt512;
      end else begin
        a_nxt    = AW'(116 * one_w - 100 * yw);
        den_nxt  = AW'(66 * one_w);
        base_nxt = bt512 - (BW'(cfg.vertical_fov) <<< 8);
      end
    end else begin
      if (3 * xw < one_w) begin
        ny_nxt  = AW'(one_w - 6 * xw);
        off_nxt = OW'(90);
      end else if (3 * xw < 2 * one_w) begin
        ny_nxt  = AW'(3 * one_w - 6 * xw);
        off_nxt = '0;
      end else begin
        ny_nxt  = AW'(5 * one_w - 6 * xw);
        off_nxt = -OW'(90);
      end
      if (yw < ffw) begin
        a_nxt    = AW'(fbase - 50 * yw);
        den_nxt  = fbase;
        base_nxt = bt512;
      end else begin
        a_nxt    = AW'(1332 * (one_w - ffw) - 1000 * (yw - ffw));
        den_nxt  = AW'(1000 * (one_w - ffw));
        base_nxt = BW'(2 * 65536);
      end
    end
  end

  // stage 1: operands; stage 2: tan multiply
  always_ff @(posedge clk) begin
    if (en) begin
      ny_r         <= ny_nxt;
      a_r          <= a_nxt;
      den_r        <= den_nxt;
      side1_r      <= '{pan_off: off_nxt, base: base_nxt};
      pan_y_r      <= NW'(ny_r);
      num_r        <= NW'(a_r) * signed'(NW'(cfg.tan_half_vfov));
      den2_r       <= NW'(den_r) <<< 16;
      side2_r      <= side1_r;
    end
  end

  assign pan_x  = NW'(1) <<< CB;
  assign pan_y  = pan_y_r;
  assign tilt_x = den2_r;
  assign tilt_y = num_r;
  assign side   = side2_r;

endmodule

// ===== hdl/msvpt_cordic.sv =====
// ----------------------------------------------------------------------------
// msvpt_cordic: pipelined arctangent lane
// Two normalizing stages, then one vectoring rotation per stage.
// ----------------------------------------------------------------------------
module msvpt_cordic #(
  parameter int W = msvpt_pkg::COORD_BITS_DEF + 33
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  output logic signed [msvpt_pkg::ZW-1:0] z_o
);
  import msvpt_pkg::*;

  localparam int KMAX = W - 32;
  localparam int KB   = $clog2(KMAX + 1);
  localparam int N    = CORDIC_STEPS;

  logic [KMAX:0]        ok;
  logic [KB-1:0]        k_nxt, k_r;
  logic [4:0]           l_nxt, l_r;
  logic signed [W-1:0]  xk, yk, ay;
  logic [30:0]          m;
  logic signed [W-1:0]  x1_r, y1_r, xs_full, ys_full;

  logic signed [CW-1:0] xs_r [0:N];
  logic signed [CW-1:0] ys_r [0:N];
  logic signed [ZW-1:0] zs_r [0:N];

  // shift amount search: right until both fit 31 bits, else left to 2^30
  always_comb begin
    for (int k = 0; k <= KMAX; k++) begin
      xk    = x_i >>> k;
      yk    = y_i >>> k;
      ok[k] = (xk < (W'(1) <<< 31)) && (yk < (W'(1) <<< 31)) &&
              (yk > -(W'(1) <<< 31));
    end
    k_nxt = KB'(KMAX);
    for (int k = KMAX; k >= 0; k--) begin
      if (ok[k]) k_nxt = KB'(k);
    end
    ay    = (y_i < 0) ? -y_i : y_i;
    m     = (x_i[30:0] > ay[30:0]) ? x_i[30:0] : ay[30:0];
    l_nxt = '0;
    for (int i = 0; i < 31; i++) begin
      if (m[i]) l_nxt = 5'(30 - i);
    end
  end

  always_comb begin
    if (k_r != '0) begin
      xs_full = x1_r >>> k_r;
      ys_full = y1_r >>> k_r;
    end else begin
      xs_full = x1_r <<< l_r;
      ys_full = y1_r <<< l_r;
    end
  end

  // normalize stages
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r     <= x_i;
      y1_r     <= y_i;
      k_r      <= k_nxt;
      l_r      <= l_nxt;
      xs_r[0]  <= CW'(xs_full);
      ys_r[0]  <= CW'(ys_full);
      zs_r[0]  <= '0;
    end
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys_r[i] >= 0) begin
          xs_r[i+1] <= xs_r[i] + (ys_r[i] >>> i);
          ys_r[i+1] <= ys_r[i] - (xs_r[i] >>> i);
          zs_r[i+1] <= zs_r[i] + atan_tab(i);
        end else begin
          xs_r[i+1] <= xs_r[i] - (ys_r[i] >>> i);
          ys_r[i+1] <= ys_r[i] + (xs_r[i] >>> i);
          zs_r[i+1] <= zs_r[i] - atan_tab(i);
        end
      end
    end
  end

  assign z_o = zs_r[N];

endmodule

// ===== hdl/multisensor_view_to_pan_tilt_top.sv =====
// ----------------------------------------------------------------------------
// multisensor_view_to_pan_tilt_top: panorama position to pan/tilt mapper
// Input word (view_x, view_y) in, output word (pan_angle, tilt_angle) out.
// ----------------------------------------------------------------------------
// Use: push coordinate words on in_valid/in_word; a word is taken when
// in_valid is high and in_stall low. Results leave on out_valid/out_word and
// are taken when out_stall is low. Angles are 1/128 degree, signed.
// The path holds two operand stages (segment select, tan multiply),
// two normalizing stages and twenty CORDIC rotation stages per angle lane,
// then the rounding/clamp output register. One word per cycle is sustained
// while the output is not held by out_stall; the pan and tilt lanes run side by side.
// The whole pipeline advances together: while the output word waits under
// out_stall, in_stall is high and every stage holds its word.
// Reset (rst_n low, synchronous) empties the pipeline and loads register
// defaults. The user must write registers over the APB port only while no
// word is in flight (the block does not enforce this); a write lands on
// the cycle with psel, penable and pwrite high.
module multisensor_view_to_pan_tilt_top #(
  parameter int COORD_BITS = msvpt_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  msvpt_pkg::in_word_t    in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output msvpt_pkg::out_word_t   out_word,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import msvpt_pkg::*;

  localparam int NW    = COORD_BITS + 33;
  localparam int DLY   = CORDIC_STEPS + 2;
  localparam int VSTG  = DLY + 2;

  cfg_t                 cfg;
  logic                 en;
  logic signed [NW-1:0] pan_x, pan_y, tilt_x, tilt_y;
  side_t                side_f;
  side_t                side_r [0:DLY-1];
  logic [VSTG-1:0]      vld_r;
  logic signed [ZW-1:0] pan_z, tilt_z;
  logic                 out_valid_r;
  out_word_t            out_word_r;
  logic signed [ZW+2:0] p16, t16;
  logic signed [ZW-7:0] pr, tr;
  logic signed [15:0]   pan_nxt, tilt_nxt;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  msvpt_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  msvpt_front #(.CB(COORD_BITS)) u_front (
    .clk(clk), .en(en), .in_word(in_word), .cfg(cfg),
    .pan_x(pan_x), .pan_y(pan_y), .tilt_x(tilt_x), .tilt_y(tilt_y),
    .side(side_f)
  );

  msvpt_cordic #(.W(NW)) u_pan (
    .clk(clk), .en(en), .x_i(pan_x), .y_i(pan_y), .z_o(pan_z)
  );

  msvpt_cordic #(.W(NW)) u_tilt (
    .clk(clk), .en(en), .x_i(tilt_x), .y_i(tilt_y), .z_o(tilt_z)
  );

  // valid bits follow the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VSTG-2:0], in_valid};
      out_valid_r <= vld_r[VSTG-1];
    end
  end

  // side data alongside the CORDIC lanes
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_f;
      for (int i = 1; i < DLY; i++) side_r[i] <= side_r[i-1];
    end
  end

  // offset, base, rounding and clamps
  always_comb begin
    p16 = -((ZW+3)'(pan_z) + ((ZW+3)'(side_r[DLY-1].pan_off) <<< 16));
    t16 = (ZW+3)'(tilt_z) + (ZW+3)'(side_r[DLY-1].base);
    pr  = (ZW-6)'((p16 + (ZW+3)'(256)) >>> 9);
    tr  = (ZW-6)'((t16 + (ZW+3)'(256)) >>> 9);
    if (pr > (ZW-6)'(32767))       pan_nxt = 16'sd32767;
    else if (pr < -(ZW-6)'(32768)) pan_nxt = -16'sd32768;
    else                           pan_nxt = 16'(pr);
    if (tr >= (ZW-6)'(11520))      tilt_nxt = 16'sd11507;
    else if (tr < -(ZW-6)'(32768)) tilt_nxt = -16'sd32768;
    else                           tilt_nxt = 16'(tr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r.pan_angle  <= pan_nxt;
      out_word_r.tilt_angle <= tilt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tilt_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.tilt_angle < 16'sd11520))
    else $error("tilt above clamp");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");
`endif

endmodule
